// ===== hw/rtl/wsd_pkg.sv =====
package wsd_pkg;

    localparam int unsigned MAX_W = 25;

    localparam logic [MAX_W-1:0] DEFAULT_MAX = MAX_W'(16 * 1024 * 1024);

    localparam logic [1:0] RK_TEXT  = 2'd0;
    localparam logic [1:0] RK_PING  = 2'd1;
    localparam logic [1:0] RK_CLOSE = 2'd2;
    localparam logic [1:0] RK_FAIL  = 2'd3;

    localparam logic [15:0] CODE_PROTOCOL    = 16'd1002;
    localparam logic [15:0] CODE_UNSUPPORTED = 16'd1003;
    localparam logic [15:0] CODE_TOO_BIG     = 16'd1009;

    typedef struct packed {
        logic        has;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        bvalid;
        logic        last;
        logic [15:0] code;
    } wsd_result_t;

endpackage

// ===== hw/rtl/wsd_core.sv =====
module wsd_core
    import wsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             kind,
    input  logic [7:0]       data_byte,
    input  logic [MAX_W-1:0] max_bytes,
    output wsd_result_t      result
);

    typedef enum logic [2:0] {
        ST_HDR0,
        ST_HDR1,
        ST_EXT,
        ST_MASK,
        ST_DATA,
        ST_HALT
    } stage_t;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [6:0] CONTROL_MAX = 7'd125;

    stage_t           stage_reg, stage_next;
    logic             final_reg, final_next;
    logic [3:0]       opcode_reg, opcode_next;
    logic [2:0]       ext_left_reg, ext_left_next;
    logic [63:0]      length_reg, length_next;
    logic [31:0]      mask_reg, mask_next;
    logic [MAX_W-1:0] index_reg, index_next;
    logic             frag_reg, frag_next;
    logic [MAX_W-1:0] msg_count_reg, msg_count_next;

    logic             cls_none;
    logic [1:0]       cls_kind;
    logic             ends_unit;
    logic             len_hi;
    logic [MAX_W:0]   msg_sum;
    logic [63:0]      ext_len;
    logic [MAX_W-1:0] index_inc;
    logic [7:0]       mask_byte;
    logic             data_end;
    logic             hd_fail;
    logic [15:0]      hd_code;

    function automatic logic len_over(input logic [63:0] len, input logic [MAX_W-1:0] mx);
        return (|len[63:MAX_W]) || (len[MAX_W-1:0] > mx);
    endfunction

    function automatic wsd_result_t fail_beat(input logic [15:0] code);
        wsd_result_t r;
        r        = '0;
        r.has    = 1'b1;
        r.kind   = RK_FAIL;
        r.code   = code;
        return r;
    endfunction

    always_comb
    begin
        cls_none = 1'b0;
        cls_kind = RK_TEXT;
        if (opcode_reg inside {OP_CONT, OP_TEXT})
        begin
            cls_kind = RK_TEXT;
        end
        else if (opcode_reg == OP_CLOSE)
        begin
            cls_kind = RK_CLOSE;
        end
        else if (opcode_reg == OP_PING)
        begin
            cls_kind = RK_PING;
        end
        else
        begin
            cls_none = 1'b1;
        end
    end

    assign ends_unit = (opcode_reg inside {OP_CONT, OP_TEXT}) ? final_reg : 1'b1;
    assign len_hi    = |length_reg[63:MAX_W];
    assign msg_sum   = {1'b0, msg_count_reg} + {1'b0, length_reg[MAX_W-1:0]};
    assign ext_len   = {length_reg[55:0], data_byte};
    assign index_inc = index_reg + MAX_W'(1);
    assign data_end  = !len_hi && (index_inc >= length_reg[MAX_W-1:0]);

    always_comb
    begin
        case (index_reg[1:0])
            2'd0:    mask_byte = mask_reg[31:24];
            2'd1:    mask_byte = mask_reg[23:16];
            2'd2:    mask_byte = mask_reg[15:8];
            default: mask_byte = mask_reg[7:0];
        endcase
    end

    // header checks once the last mask byte is in
    always_comb
    begin
        hd_fail = 1'b0;
        hd_code = CODE_PROTOCOL;
        if (opcode_reg[3])
        begin
            hd_fail = !final_reg || (|length_reg[63:7]) || (length_reg[6:0] > CONTROL_MAX);
        end
        else if (opcode_reg == OP_BIN)
        begin
            hd_fail = 1'b1;
            hd_code = CODE_UNSUPPORTED;
        end
        else if (opcode_reg == OP_TEXT)
        begin
            hd_fail = frag_reg;
        end
        else if (opcode_reg == OP_CONT)
        begin
            if (!frag_reg)
            begin
                hd_fail = 1'b1;
            end
            else if (len_hi || (msg_sum > {1'b0, max_bytes}))
            begin
                hd_fail = 1'b1;
                hd_code = CODE_TOO_BIG;
            end
        end
        else
        begin
            hd_fail = 1'b1;
        end
    end

    always_comb
    begin
        stage_next     = stage_reg;
        final_next     = final_reg;
        opcode_next    = opcode_reg;
        ext_left_next  = ext_left_reg;
        length_next    = length_reg;
        mask_next      = mask_reg;
        index_next     = index_reg;
        frag_next      = frag_reg;
        msg_count_next = msg_count_reg;
        result         = '0;

        if (kind)
        begin
            stage_next     = ST_HDR0;
            final_next     = 1'b0;
            opcode_next    = '0;
            ext_left_next  = '0;
            length_next    = '0;
            mask_next      = '0;
            index_next     = '0;
            frag_next      = 1'b0;
            msg_count_next = '0;
        end
        else
        begin
            case (stage_reg)
                ST_HDR0:
                begin
                    final_next    = data_byte[7];
                    opcode_next   = data_byte[3:0];
                    ext_left_next = data_byte[6:4];
                    stage_next    = ST_HDR1;
                end
                ST_HDR1:
                begin
                    if ((ext_left_reg != 3'd0) || !data_byte[7])
                    begin
                        result     = fail_beat(CODE_PROTOCOL);
                        stage_next = ST_HALT;
                    end
                    else if (data_byte[6:0] == LEN_EXT16)
                    begin
                        length_next   = '0;
                        ext_left_next = 3'd1;
                        stage_next    = ST_EXT;
                    end
                    else if (data_byte[6:0] == LEN_EXT64)
                    begin
                        length_next   = '0;
                        ext_left_next = 3'd7;
                        stage_next    = ST_EXT;
                    end
                    else
                    begin
                        length_next = {57'd0, data_byte[6:0]};
                        if ({18'd0, data_byte[6:0]} > max_bytes)
                        begin
                            result     = fail_beat(CODE_TOO_BIG);
                            stage_next = ST_HALT;
                        end
                        else
                        begin
                            ext_left_next = 3'd3;
                            stage_next    = ST_MASK;
                        end
                    end
                end
                ST_EXT:
                begin
                    length_next = ext_len;
                    if (ext_left_reg != 3'd0)
                    begin
                        ext_left_next = ext_left_reg - 3'd1;
                    end
                    else if (len_over(ext_len, max_bytes))
                    begin
                        result     = fail_beat(CODE_TOO_BIG);
                        stage_next = ST_HALT;
                    end
                    else
                    begin
                        ext_left_next = 3'd3;
                        stage_next    = ST_MASK;
                    end
                end
                ST_MASK:
                begin
                    mask_next = {mask_reg[23:0], data_byte};
                    if (ext_left_reg != 3'd0)
                    begin
                        ext_left_next = ext_left_reg - 3'd1;
                    end
                    else if (hd_fail)
                    begin
                        result     = fail_beat(hd_code);
                        stage_next = ST_HALT;
                    end
                    else
                    begin
                        if (opcode_reg == OP_TEXT && !final_reg)
                        begin
                            frag_next      = 1'b1;
                            msg_count_next = length_reg[MAX_W-1:0];
                        end
                        else if (opcode_reg == OP_CONT)
                        begin
                            if (final_reg)
                            begin
                                frag_next      = 1'b0;
                                msg_count_next = '0;
                            end
                            else
                            begin
                                msg_count_next = msg_sum[MAX_W-1:0];
                            end
                        end
                        index_next = '0;
                        if (length_reg != 64'd0)
                        begin
                            stage_next = ST_DATA;
                        end
                        else
                        begin
                            stage_next = (!cls_none && cls_kind == RK_CLOSE) ? ST_HALT : ST_HDR0;
                            if (!cls_none && ends_unit)
                            begin
                                result.has  = 1'b1;
                                result.kind = cls_kind;
                                result.last = 1'b1;
                            end
                        end
                    end
                end
                ST_DATA:
                begin
                    index_next = index_inc;
                    if (data_end)
                    begin
                        stage_next = (!cls_none && cls_kind == RK_CLOSE) ? ST_HALT : ST_HDR0;
                    end
                    if (!cls_none)
                    begin
                        result.has    = 1'b1;
                        result.kind   = cls_kind;
                        result.data   = data_byte ^ mask_byte;
                        result.bvalid = 1'b1;
                        result.last   = data_end & ends_unit;
                    end
                end
                default:
                begin
                    stage_next = stage_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= ST_HDR0;
            final_reg     <= 1'b0;
            opcode_reg    <= '0;
            ext_left_reg  <= '0;
            length_reg    <= '0;
            mask_reg      <= '0;
            index_reg     <= '0;
            frag_reg      <= 1'b0;
            msg_count_reg <= '0;
        end
        else if (step)
        begin
            stage_reg     <= stage_next;
            final_reg     <= final_next;
            opcode_reg    <= opcode_next;
            ext_left_reg  <= ext_left_next;
            length_reg    <= length_next;
            mask_reg      <= mask_next;
            index_reg     <= index_next;
            frag_reg      <= frag_next;
            msg_count_reg <= msg_count_next;
        end
    end

endmodule

// ===== hw/rtl/websocket_frame_deframer.sv =====
// WebSocket client-to-server frame deframer.
// rx channel: one stream beat per cycle (kind, data_byte). kind 1 starts a new
//   connection and clears all parse state; the size limit register is kept.
// res channel: text, ping and close payload bytes unmasked, end markers with
//   last set, and one failure beat carrying the close code.
// cfg: cfg_we/cfg_wdata write max_message_bytes (reset 16 MiB); write only
//   while no beat is in flight.
// Path: an accepted beat goes into the input register, then through the
//   header/payload logic into the result register.
// Throughput: one beat per cycle, sustained, limited only by the res side.
// Reset: parser waits for a first header byte, no result pending.
// A stalled result holds in the result register; the input register still
//   takes one more beat, then rx_stall rises until the result moves.
// After a failure or a close frame the parser drops bytes until kind is 1.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [MAX_W-1:0] cfg_wdata,
    input  logic             rx_valid,
    output logic             rx_stall,
    input  logic             kind,
    input  logic [7:0]       data_byte,
    output logic             res_valid,
    input  logic             res_stall,
    output logic [1:0]       result_kind,
    output logic [7:0]       payload_byte,
    output logic             byte_valid,
    output logic             last,
    output logic [15:0]      fail_code
);

    logic [MAX_W-1:0] max_reg;
    logic             in_vld_reg;
    logic             in_kind_reg;
    logic [7:0]       in_byte_reg;
    logic             res_vld_reg;
    wsd_result_t      res_reg;
    wsd_result_t      core_res;
    logic             fire;
    logic             rx_take;

    assign fire     = in_vld_reg && (!res_vld_reg || !res_stall);
    assign rx_stall = in_vld_reg && !fire;
    assign rx_take  = rx_valid && !rx_stall;

    wsd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .kind      (in_kind_reg),
        .data_byte (in_byte_reg),
        .max_bytes (max_reg),
        .result    (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg     <= DEFAULT_MAX;
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_reg <= cfg_wdata;
            end
            if (rx_take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_vld_reg <= 1'b0;
            end
            if (fire && core_res.has)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (res_vld_reg && !res_stall)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            in_kind_reg <= kind;
            in_byte_reg <= data_byte;
        end
        if (fire && core_res.has)
        begin
            res_reg <= core_res;
        end
    end

    assign res_valid    = res_vld_reg;
    assign result_kind  = res_reg.kind;
    assign payload_byte = res_reg.data;
    assign byte_valid   = res_reg.bvalid;
    assign last         = res_reg.last;
    assign fail_code    = res_reg.code;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> in_vld_reg)
        else $error("rx_stall with empty input register");

    a_code_only_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && result_kind != RK_FAIL) |-> (fail_code == 16'd0))
        else $error("fail_code set on a data beat");

    a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_kind_reg) |=> !$rose(res_valid))
        else $error("result produced by a connection restart");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && result_kind == RK_FAIL) |-> (!byte_valid && !last))
        else $error("failure beat flagged as data");

endmodule
